/* design/sensor_hysteresis_actuator_control_macros.svh */
// Assertion macros for the sensor hysteresis actuator control block.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef SENSOR_HYSTERESIS_ACTUATOR_CONTROL_MACROS_SVH
`define SENSOR_HYSTERESIS_ACTUATOR_CONTROL_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SHAC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SHAC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/shac_pkg.sv */
// Package for the sensor hysteresis actuator control block: payload layouts,
// register indexes, constants and threshold clamping helpers. No dependencies.
package shac_pkg;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int LEVEL_W    = 6;
   localparam int TEMP10_W   = 12;

   localparam logic [7:0] ANGLE_MAX        = 8'd180;
   localparam logic [7:0] ACTION_OPEN_MIN  = 8'd170;
   localparam logic [7:0] ACTION_CLOSE_MAX = 8'd10;
   localparam logic [LEVEL_W-1:0] LEVEL_CAP = 6'd50;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TEMP_OPEN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TEMP_CLOSE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LIGHT_ON   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LIGHT_OFF  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SOIL_ON    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SOIL_OFF   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_GAS_ON     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_GAS_OFF    = 3'd7;

   // Alarm bit positions
   localparam int ALM_SOIL  = 0;
   localparam int ALM_GAS   = 1;
   localparam int ALM_TLOW  = 2;
   localparam int ALM_THIGH = 3;

   // Servo action classes
   localparam logic [1:0] ACT_OPEN   = 2'd0;
   localparam logic [1:0] ACT_CLOSED = 2'd1;
   localparam logic [1:0] ACT_HOLD   = 2'd2;

   // Input item payload, last member in the lowest bits
   typedef struct packed {
      logic [6:0]        pad;
      logic signed [9:0] servo_request;
      logic signed [1:0] lamp_request;
      logic signed [1:0] fan_request;
      logic signed [1:0] pump_request;
      logic signed [1:0] mode_request;
      logic [3:0]        temp_tenths;
      logic [7:0]        temp_whole;
      logic              temp_valid;
      logic [5:0]        gas_volt_x10;
      logic [5:0]        soil_volt_x10;
      logic [5:0]        light_volt_x10;
   } req_data_type;

   typedef struct packed {
      logic [5:0] pad;
      logic [1:0] vent_class;
      logic       manual_mode;
      logic [3:0] alarm_bits;
      logic [7:0] vent_angle;
      logic       lamp_on;
      logic       fan_on;
      logic       pump_on;
   } rsp_data_type;

   function automatic logic [LEVEL_W-1:0] cap_level(input logic [LEVEL_W-1:0] v);
      return (v > LEVEL_CAP) ? LEVEL_CAP : v;
   endfunction

   // Strict keeps off below on (off is zero when on is zero); otherwise off may equal on
   function automatic logic [LEVEL_W-1:0] fix_off(input logic [LEVEL_W-1:0] off,
                                                  input logic [LEVEL_W-1:0] on,
                                                  input logic strict);
      logic [LEVEL_W-1:0] res;
      if (strict) begin
         if (off >= on) begin
            res = (on == '0) ? '0 : on - 1'b1;
         end else begin
            res = off;
         end
      end else begin
         res = (off > on) ? on : off;
      end
      return res;
   endfunction

   function automatic logic [TEMP10_W-1:0] temp_scaled(input logic [7:0] whole,
                                                      input logic [3:0] tenths);
      return {1'b0, whole, 3'b000} + {3'b000, whole, 1'b0} + {8'd0, tenths};
   endfunction

   function automatic logic [TEMP10_W-1:0] level_x10(input logic [LEVEL_W-1:0] v);
      return {3'b000, v, 3'b000} + {5'd0, v, 1'b0};
   endfunction

   function automatic logic [1:0] action_of(input logic [7:0] angle);
      logic [1:0] res;
      if (angle >= ACTION_OPEN_MIN) begin
         res = ACT_OPEN;
      end else if (angle <= ACTION_CLOSE_MAX) begin
         res = ACT_CLOSED;
      end else begin
         res = ACT_HOLD;
      end
      return res;
   endfunction

endpackage

/* design/sensor_hysteresis_actuator_control.sv */
// Top level of the sensor hysteresis actuator control block.
// Depends on shac_pkg and sensor_hysteresis_actuator_control_macros.svh.
//
//   channel  ports                         carries
//   -------  ----------------------------  --------------------------------------
//   req      req_tvalid/tready/tdata/tuser  sensor sample or manual command
//   rsp      rsp_tvalid/tready/tdata        actuator states, alarms, mode, action
//   csr      csr_valid/ready/index/data     threshold register writes
//
// An item is registered on entry and resolved against the state when it advances
// into the result register, which presents it; one item per cycle while rsp_tready holds.
// The input stage stalls when the result register is full and not being taken;
// it advances whenever the result register is empty or being taken.
// Synchronous reset clears the state and the valid flags and loads the default
// thresholds. The csr port is always ready.
`include "sensor_hysteresis_actuator_control_macros.svh"

module sensor_hysteresis_actuator_control (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // light_volt_x10, soil_volt_x10, gas_volt_x10, temp_valid, temp_whole,
   // temp_tenths, mode_request, pump_request, fan_request, lamp_request,
   // servo_request, zero fill
   input  logic [shac_pkg::REQ_DATA_W-1:0]    req_tdata,
   // cmd
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // pump_on, fan_on, lamp_on, vent_angle, alarm_bits, manual_mode,
   // vent_class, zero fill
   output logic [shac_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [shac_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [shac_pkg::LEVEL_W-1:0]       csr_data
);
   import shac_pkg::*;

   // Thresholds as written
   logic [LEVEL_W-1:0] cfg_ff [8];

   // Input stage
   logic         in_valid_ff;
   req_data_type req_ff;
   logic         cmd_ff;

   // Architectural state
   logic       mode_ff, mode_in;
   logic       pump_ff, pump_in;
   logic       fan_ff, fan_in;
   logic       lamp_ff, lamp_in;
   logic [7:0] angle_ff, angle_in;
   logic [3:0] alarm_ff, alarm_in;

   // Result register
   logic         out_valid_ff;
   rsp_data_type rsp_ff;
   rsp_data_type rsp_in;

   logic advance;

   // Thresholds as used
   logic [LEVEL_W-1:0] t_open, t_close, l_on, l_off, s_on, s_off, g_on, g_off;
   logic [TEMP10_W-1:0] t10;
   logic                gas_trip;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = rsp_ff;

   always_comb begin
      t_open  = cap_level(cfg_ff[REG_TEMP_OPEN]);
      t_close = fix_off(cfg_ff[REG_TEMP_CLOSE], t_open, 1'b1);
      l_on    = cap_level(cfg_ff[REG_LIGHT_ON]);
      l_off   = fix_off(cfg_ff[REG_LIGHT_OFF], l_on, 1'b1);
      s_on    = cap_level(cfg_ff[REG_SOIL_ON]);
      s_off   = fix_off(cfg_ff[REG_SOIL_OFF], s_on, 1'b0);
      g_on    = cap_level(cfg_ff[REG_GAS_ON]);
      g_off   = fix_off(cfg_ff[REG_GAS_OFF], g_on, 1'b0);
      t10     = temp_scaled(req_ff.temp_whole, req_ff.temp_tenths);
      gas_trip = req_ff.gas_volt_x10 > g_on;
   end

   // Resolve one item against the current state
   always_comb begin
      mode_in  = mode_ff;
      pump_in  = pump_ff;
      fan_in   = fan_ff;
      lamp_in  = lamp_ff;
      angle_in = angle_ff;
      alarm_in = alarm_ff;
      if (!cmd_ff) begin
         // samples act only in auto mode
         if (!mode_ff) begin
            alarm_in = '0;
            if (req_ff.light_volt_x10 > l_on) begin
               lamp_in = 1'b1;
            end else if (req_ff.light_volt_x10 < l_off) begin
               lamp_in = 1'b0;
            end
            if (req_ff.soil_volt_x10 > s_on) begin
               pump_in = 1'b1;
               alarm_in[ALM_SOIL] = 1'b1;
            end else if (req_ff.soil_volt_x10 < s_off) begin
               pump_in = 1'b0;
            end
            if (gas_trip) begin
               fan_in = 1'b1;
               alarm_in[ALM_GAS] = 1'b1;
            end else if (req_ff.gas_volt_x10 < g_off) begin
               fan_in = 1'b0;
            end
            if (gas_trip || (fan_in && (req_ff.gas_volt_x10 >= g_off))) begin
               angle_in = ANGLE_MAX;
            end else if (req_ff.temp_valid) begin
               if (t10 <= level_x10(t_close)) begin
                  angle_in = '0;
                  alarm_in[ALM_TLOW] = 1'b1;
               end else if (t10 >= level_x10(t_open)) begin
                  angle_in = ANGLE_MAX;
                  alarm_in[ALM_THIGH] = 1'b1;
               end
            end
         end
      end else begin
         // a negative request keeps the setting
         if (!req_ff.mode_request[1]) begin
            mode_in = req_ff.mode_request[0];
         end
         if (mode_in) begin
            if (!req_ff.pump_request[1]) begin
               pump_in = req_ff.pump_request[0];
            end
            if (!req_ff.fan_request[1]) begin
               fan_in = req_ff.fan_request[0];
            end
            if (!req_ff.lamp_request[1]) begin
               lamp_in = req_ff.lamp_request[0];
            end
            if (!req_ff.servo_request[9]) begin
               if (req_ff.servo_request[8:0] > {1'b0, ANGLE_MAX}) begin
                  angle_in = ANGLE_MAX;
               end else begin
                  angle_in = req_ff.servo_request[7:0];
               end
            end
         end
      end
   end

   always_comb begin
      rsp_in              = '0;
      rsp_in.pump_on      = pump_in;
      rsp_in.fan_on       = fan_in;
      rsp_in.lamp_on      = lamp_in;
      rsp_in.vent_angle   = angle_in;
      rsp_in.alarm_bits   = alarm_in;
      rsp_in.manual_mode  = mode_in;
      rsp_in.vent_class   = action_of(angle_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[REG_TEMP_OPEN]  <= 6'd30;
         cfg_ff[REG_TEMP_CLOSE] <= 6'd20;
         cfg_ff[REG_LIGHT_ON]   <= 6'd30;
         cfg_ff[REG_LIGHT_OFF]  <= 6'd20;
         cfg_ff[REG_SOIL_ON]    <= 6'd20;
         cfg_ff[REG_SOIL_OFF]   <= 6'd15;
         cfg_ff[REG_GAS_ON]     <= 6'd20;
         cfg_ff[REG_GAS_OFF]    <= 6'd15;
      end else if (csr_valid && csr_ready) begin
         cfg_ff[csr_index] <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= 1'b0;
         pump_ff      <= 1'b0;
         fan_ff       <= 1'b0;
         lamp_ff      <= 1'b0;
         angle_ff     <= '0;
         alarm_ff     <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            mode_ff      <= mode_in;
            pump_ff      <= pump_in;
            fan_ff       <= fan_in;
            lamp_ff      <= lamp_in;
            angle_ff     <= angle_in;
            alarm_ff     <= alarm_in;
         end else if (rsp_tready) begin
            // drop the result once taken
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_ff <= req_data_type'(req_tdata);
         cmd_ff <= req_tuser;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   `SHAC_ASSERT_NEXT(a_advance_loads_rsp, clock, reset, advance, out_valid_ff,
                     "result lost after advance")
   `SHAC_ASSERT_NEXT(a_stalled_item_held, clock, reset, in_valid_ff && !advance,
                     in_valid_ff, "stalled item dropped")
   `SHAC_ASSERT_SAME(a_rsp_mode_match, clock, reset, out_valid_ff,
                     rsp_ff.manual_mode == mode_ff, "result mode differs from state")
   `SHAC_ASSERT_SAME(a_empty_stage_ready, clock, reset, !in_valid_ff, req_tready,
                     "empty input stage not ready")

endmodule
